@@ sv/packet_header_statistics_macros.svh @@
// Assertion macros for the packet header statistics block.
`ifndef PACKET_HEADER_STATISTICS_MACROS_SVH
`define PACKET_HEADER_STATISTICS_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PHS_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phs: same-cycle property failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phs: next-cycle property failed");

`endif

@@ sv/phs_pkg.sv @@
// Package: constants, memory layout and types of the packet header statistics block.
`timescale 1ns / 1ps
`default_nettype none
package phs_pkg;

    localparam int PORT_LIMIT        = 1024;
    localparam int SNAP_LENGTH       = 1518;
    localparam int LINK_HEADER_BYTES = 14;

    localparam int CNT_W  = 32;
    localparam int BIN_W  = 11;
    localparam int LEN_W  = 18;
    localparam int OCT_N  = 256;
    localparam int PROTO_N = 4;

    // Counter memory layout: every histogram is a window of one memory
    localparam int SRC_OCT_BASE = 0;
    localparam int DST_OCT_BASE = SRC_OCT_BASE + OCT_N;
    localparam int FLAG_BASE    = DST_OCT_BASE + OCT_N;
    localparam int PROTO_BASE   = FLAG_BASE + OCT_N;
    localparam int SPORT_BASE   = PROTO_BASE + PROTO_N;
    localparam int DPORT_BASE   = SPORT_BASE + PORT_LIMIT;
    localparam int LEN_BASE     = DPORT_BASE + PORT_LIMIT;
    localparam int MEM_DEPTH    = LEN_BASE + SNAP_LENGTH;
    localparam int ADDR_W       = $clog2(MEM_DEPTH);

    localparam logic [7:0] PROTO_NUM_TCP  = 8'd6;
    localparam logic [7:0] PROTO_NUM_UDP  = 8'd17;
    localparam logic [7:0] PROTO_NUM_ICMP = 8'd1;
    localparam logic [7:0] PROTO_NUM_IP   = 8'd0;

    localparam logic [1:0] PROTO_SLOT_TCP  = 2'd0;
    localparam logic [1:0] PROTO_SLOT_UDP  = 2'd1;
    localparam logic [1:0] PROTO_SLOT_ICMP = 2'd2;
    localparam logic [1:0] PROTO_SLOT_IP   = 2'd3;

    localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
    localparam logic       OP_COUNT = 1'b0;

    // Counter updates a packet can cause, one bit each
    localparam int JOB_SRC_OCT = 0;
    localparam int JOB_DST_OCT = 1;
    localparam int JOB_PROTO   = 2;
    localparam int JOB_FLAGS   = 3;
    localparam int JOB_SPORT   = 4;
    localparam int JOB_DPORT   = 5;
    localparam int JOB_LENGTH  = 6;
    localparam int JOB_N       = 7;

    typedef enum logic [2:0] {
        ST_COUNTED   = 3'd0,
        ST_BAD_IP    = 3'd1,
        ST_BAD_TCP   = 3'd2,
        ST_OVERSIZED = 3'd3,
        ST_NEGATIVE  = 3'd4,
        ST_READ      = 3'd5
    } phs_status_t;

    typedef enum logic [2:0] {
        TBL_SRC_OCT = 3'd0,
        TBL_DST_OCT = 3'd1,
        TBL_SPORT   = 3'd2,
        TBL_DPORT   = 3'd3,
        TBL_PROTO   = 3'd4,
        TBL_SIZE    = 3'd5,
        TBL_FLAGS   = 3'd6
    } phs_table_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_DONE
    } phs_state_t;

    typedef struct packed {
        logic                          is_read;
        logic                          read_ok;
        logic [ADDR_W-1:0]             read_addr;
        logic [JOB_N-1:0]              job_mask;
        logic [JOB_N-1:0][ADDR_W-1:0]  job_addr;
        phs_status_t                   status;
        logic [BIN_W-1:0]              size_bin;
    } phs_plan_t;

endpackage
`default_nettype wire

@@ sv/phs_decode.sv @@
// Header decode: classifies one transaction into counter updates, status and size bin.
`timescale 1ns / 1ps
`default_nettype none
module phs_decode
    import phs_pkg::*;
(
    input  logic        op,
    input  logic [3:0]  ip_header_words,
    input  logic [7:0]  ip_protocol,
    input  logic [7:0]  src_addr_octet,
    input  logic [7:0]  dst_addr_octet,
    input  logic [15:0] ip_total_length,
    input  logic [3:0]  tcp_offset_words,
    input  logic [7:0]  tcp_flag_bits,
    input  logic [15:0] source_port,
    input  logic [15:0] destination_port,
    input  logic [2:0]  read_table,
    input  logic [10:0] read_index,
    output phs_plan_t   plan
);

    logic [5:0]        ip_bytes;
    logic [5:0]        tcp_bytes;
    logic [6:0]        ip_tcp_bytes;
    logic [LEN_W-1:0]  hdr_bytes;
    logic [15:0]       payload;
    logic [LEN_W-1:0]  tcp_end;
    logic              negative;
    logic              sport_ok;
    logic              dport_ok;
    logic [LEN_W-1:0]  rd_idx;
    logic [BIN_W-1:0]  len_bin;

    assign ip_bytes     = {ip_header_words, 2'b00};
    assign tcp_bytes    = {tcp_offset_words, 2'b00};
    assign ip_tcp_bytes = {1'b0, ip_bytes} + {1'b0, tcp_bytes};
    assign hdr_bytes    = LEN_W'(LINK_HEADER_BYTES) + LEN_W'(ip_bytes);
    assign negative     = ip_total_length < {9'd0, ip_tcp_bytes};
    assign payload      = ip_total_length - {9'd0, ip_tcp_bytes};
    assign tcp_end      = LEN_W'(payload) + hdr_bytes;
    assign sport_ok     = LEN_W'(source_port) < LEN_W'(PORT_LIMIT);
    assign dport_ok     = LEN_W'(destination_port) < LEN_W'(PORT_LIMIT);
    assign rd_idx       = LEN_W'(read_index);

    always_comb
    begin
        plan          = '0;
        len_bin       = '0;
        plan.is_read  = (op != OP_COUNT);
        plan.status   = ST_COUNTED;

        plan.job_addr[JOB_SRC_OCT] = ADDR_W'(SRC_OCT_BASE) + ADDR_W'(src_addr_octet);
        plan.job_addr[JOB_DST_OCT] = ADDR_W'(DST_OCT_BASE) + ADDR_W'(dst_addr_octet);
        plan.job_addr[JOB_FLAGS]   = ADDR_W'(FLAG_BASE) + ADDR_W'(tcp_flag_bits);
        plan.job_addr[JOB_SPORT]   = ADDR_W'(SPORT_BASE) + ADDR_W'(source_port);
        plan.job_addr[JOB_DPORT]   = ADDR_W'(DPORT_BASE) + ADDR_W'(destination_port);

        case (ip_protocol)
            PROTO_NUM_TCP:  plan.job_addr[JOB_PROTO] = ADDR_W'(PROTO_BASE) + ADDR_W'(PROTO_SLOT_TCP);
            PROTO_NUM_UDP:  plan.job_addr[JOB_PROTO] = ADDR_W'(PROTO_BASE) + ADDR_W'(PROTO_SLOT_UDP);
            PROTO_NUM_ICMP: plan.job_addr[JOB_PROTO] = ADDR_W'(PROTO_BASE) + ADDR_W'(PROTO_SLOT_ICMP);
            default:        plan.job_addr[JOB_PROTO] = ADDR_W'(PROTO_BASE) + ADDR_W'(PROTO_SLOT_IP);
        endcase

        if (plan.is_read) begin
            plan.status = ST_READ;
            case (read_table)
                TBL_SRC_OCT:
                begin
                    plan.read_ok   = rd_idx < LEN_W'(OCT_N);
                    plan.read_addr = ADDR_W'(SRC_OCT_BASE) + ADDR_W'(read_index);
                end
                TBL_DST_OCT:
                begin
                    plan.read_ok   = rd_idx < LEN_W'(OCT_N);
                    plan.read_addr = ADDR_W'(DST_OCT_BASE) + ADDR_W'(read_index);
                end
                TBL_SPORT:
                begin
                    plan.read_ok   = rd_idx < LEN_W'(PORT_LIMIT);
                    plan.read_addr = ADDR_W'(SPORT_BASE) + ADDR_W'(read_index);
                end
                TBL_DPORT:
                begin
                    plan.read_ok   = rd_idx < LEN_W'(PORT_LIMIT);
                    plan.read_addr = ADDR_W'(DPORT_BASE) + ADDR_W'(read_index);
                end
                TBL_PROTO:
                begin
                    plan.read_ok   = rd_idx < LEN_W'(PROTO_N);
                    plan.read_addr = ADDR_W'(PROTO_BASE) + ADDR_W'(read_index);
                end
                TBL_SIZE:
                begin
                    plan.read_ok   = rd_idx < LEN_W'(SNAP_LENGTH);
                    plan.read_addr = ADDR_W'(LEN_BASE) + ADDR_W'(read_index);
                end
                TBL_FLAGS:
                begin
                    plan.read_ok   = rd_idx < LEN_W'(OCT_N);
                    plan.read_addr = ADDR_W'(FLAG_BASE) + ADDR_W'(read_index);
                end
                default:
                begin
                    plan.read_ok   = 1'b0;
                    plan.read_addr = '0;
                end
            endcase
        end else if (ip_header_words < MIN_HDR_WORDS) begin
            plan.status = ST_BAD_IP;
        end else begin
            plan.job_mask[JOB_SRC_OCT] = 1'b1;
            plan.job_mask[JOB_DST_OCT] = 1'b1;
            if (ip_protocol != PROTO_NUM_TCP) begin
                // Unclassified protocols still count addresses and header size
                plan.job_mask[JOB_PROTO] = (ip_protocol == PROTO_NUM_UDP)
                                         || (ip_protocol == PROTO_NUM_ICMP)
                                         || (ip_protocol == PROTO_NUM_IP);
                if (hdr_bytes < LEN_W'(SNAP_LENGTH)) begin
                    plan.job_mask[JOB_LENGTH] = 1'b1;
                    len_bin = BIN_W'(hdr_bytes);
                end else begin
                    plan.status = ST_OVERSIZED;
                end
            end else begin
                plan.job_mask[JOB_PROTO] = 1'b1;
                if (tcp_offset_words < MIN_HDR_WORDS) begin
                    plan.status = ST_BAD_TCP;
                end else begin
                    plan.job_mask[JOB_FLAGS] = 1'b1;
                    plan.job_mask[JOB_SPORT] = sport_ok;
                    plan.job_mask[JOB_DPORT] = dport_ok;
                    if (negative) begin
                        plan.status = ST_NEGATIVE;
                    end else if (tcp_end < LEN_W'(SNAP_LENGTH)) begin
                        plan.job_mask[JOB_LENGTH] = 1'b1;
                        len_bin = BIN_W'(payload);
                    end else begin
                        plan.status = ST_OVERSIZED;
                    end
                end
            end
        end

        plan.size_bin            = len_bin;
        plan.job_addr[JOB_LENGTH] = ADDR_W'(LEN_BASE) + ADDR_W'(len_bin);
    end

endmodule
`default_nettype wire

@@ sv/phs_ram.sv @@
// Counter memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module phs_ram #(
    parameter  int DEPTH = 1024,
    parameter  int WIDTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ sv/packet_header_statistics.sv @@
// Top level: packet header statistics with all histograms in one counter memory.
// Flow: a count transaction bumps its counters (up to 7) one at a time, each through
//   READ then UPDATE; a read passes both once; nothing to bump or read goes to DONE.
// Busy: a new transaction is taken only in IDLE, after the last one has left DONE;
//   the counter memory is read and written back for one counter at a time.
// Reset: rst_n clears control at once, then a clearing pass zeroes all MEM_DEPTH
//   entries of the counter memory, one entry a cycle, with in_stall held high.
`timescale 1ns / 1ps
`default_nettype none
module packet_header_statistics
    import phs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [3:0]  ip_header_words,
    input  logic [7:0]  ip_protocol,
    input  logic [7:0]  src_addr_octet,
    input  logic [7:0]  dst_addr_octet,
    input  logic [15:0] ip_total_length,
    input  logic [3:0]  tcp_offset_words,
    input  logic [7:0]  tcp_flag_bits,
    input  logic [15:0] source_port,
    input  logic [15:0] destination_port,
    input  logic [2:0]  read_table,
    input  logic [10:0] read_index,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] count_value,
    output logic [10:0] size_bin
);

    // ------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------
    phs_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    phs_plan_t         plan_reg, plan_next;
    logic [JOB_N-1:0]  jobs_reg, jobs_next;
    logic [CNT_W-1:0]  value_reg, value_next;

    logic              out_valid_reg, out_valid_next;
    phs_status_t       status_reg, status_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BIN_W-1:0]  bin_reg, bin_next;

    phs_plan_t         dec_plan;
    logic              in_fire;
    logic              out_free;
    logic              clr_last;
    logic [JOB_N-1:0]  pick;
    logic [ADDR_W-1:0] pick_addr;
    logic [JOB_N-1:0]  jobs_left;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CNT_W-1:0]  ram_rdata;

    // ------------------------------------------------------------------
    // Decode the incoming transaction straight off the ports
    // ------------------------------------------------------------------
    phs_decode u_decode (
        .op               (op),
        .ip_header_words  (ip_header_words),
        .ip_protocol      (ip_protocol),
        .src_addr_octet   (src_addr_octet),
        .dst_addr_octet   (dst_addr_octet),
        .ip_total_length  (ip_total_length),
        .tcp_offset_words (tcp_offset_words),
        .tcp_flag_bits    (tcp_flag_bits),
        .source_port      (source_port),
        .destination_port (destination_port),
        .read_table       (read_table),
        .read_index       (read_index),
        .plan             (dec_plan)
    );

    // ------------------------------------------------------------------
    // All seven histograms share one memory; the layout lives in the package
    // ------------------------------------------------------------------
    phs_ram #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (CNT_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Take only in IDLE; a finished result may still sit in the output register
    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign clr_last = (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1));

    // Work the pending counter updates lowest bit first
    assign pick      = jobs_reg & (~jobs_reg + JOB_N'(1));
    assign jobs_left = jobs_reg & ~pick;

    always_comb
    begin
        pick_addr = '0;
        for (int i = 0; i < JOB_N; i++) begin
            if (pick[i]) begin
                pick_addr = pick_addr | plan_reg.job_addr[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire) begin
                    if (dec_plan.is_read) begin
                        state_next = dec_plan.read_ok ? S_READ : S_DONE;
                    end else begin
                        state_next = (dec_plan.job_mask != '0) ? S_READ : S_DONE;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (plan_reg.is_read || (jobs_left == '0)) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Memory control and register updates
    // ------------------------------------------------------------------
    always_comb
    begin
        ram_we         = 1'b0;
        ram_waddr      = pick_addr;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = pick_addr;
        clr_addr_next  = clr_addr_reg;
        plan_next      = plan_reg;
        jobs_next      = jobs_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        count_next     = count_reg;
        bin_next       = bin_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // Zero one entry a cycle
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            S_IDLE:
            begin
                if (in_fire) begin
                    plan_next  = dec_plan;
                    jobs_next  = dec_plan.job_mask;
                    value_next = '0;
                end
            end
            S_READ:
            begin
                ram_re    = 1'b1;
                ram_raddr = plan_reg.is_read ? plan_reg.read_addr : pick_addr;
            end
            S_UPDATE:
            begin
                if (plan_reg.is_read) begin
                    value_next = ram_rdata;
                end else begin
                    // Saturating increment, written back to the entry just read
                    ram_we    = 1'b1;
                    ram_waddr = pick_addr;
                    ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + CNT_W'(1);
                    jobs_next = jobs_left;
                end
            end
            S_DONE:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    status_next    = plan_reg.status;
                    count_next     = value_reg;
                    bin_next       = plan_reg.size_bin;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            jobs_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            jobs_reg      <= jobs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plan_reg   <= plan_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        count_reg  <= count_next;
        bin_reg    <= bin_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign count_value = count_reg;
    assign size_bin    = bin_reg;

endmodule
`default_nettype wire

@@ sv/phs_checker.sv @@
// Port checker for the packet header statistics block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "packet_header_statistics_macros.svh"
module phs_checker
    import phs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [31:0] count_value,
    input  logic [10:0] size_bin
);

    logic [45:0] out_word;

    assign out_word = {status, count_value, size_bin};

    // Hold a stalled result
    `PHS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

    // One transaction at a time: busy right after an acceptance
    `PHS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // Only a read returns a counter value
    `PHS_ASSERT_IMPLIES(a_count_only_on_read, out_valid && (status != ST_READ), count_value == '0)

    // No size bin for reads or rejected packets
    `PHS_ASSERT_IMPLIES(a_no_bin_when_failed, out_valid && (status != ST_COUNTED), size_bin == '0)

endmodule

bind packet_header_statistics phs_checker u_phs_checker (.*);
`default_nettype wire
